>>> hdl/rdbm_pkg.sv
package rdbm_pkg;

    localparam int POINTS   = 1024;
    localparam int SAMPLE_W = 16;
    localparam int BIN_W    = 10;
    localparam int PART_W   = 18;
    localparam int MAG_W    = 17;
    localparam int SQ_W     = 34;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_BIN    = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RUN    = 7'b0000010,
        ST_SCALE  = 7'b0000100,
        ST_SQUARE = 7'b0001000,
        ST_SUM    = 7'b0010000,
        ST_ROOT   = 7'b0100000,
        ST_HOLD   = 7'b1000000
    } state_t;

endpackage

>>> hdl/real_dft_bin_magnitude_top.sv
// channel  | beat                          | tdata / tuser
// s_axis   | sample write or bin request   | tdata: sample, bin_index; tuser: kind
// m_axis   | one result per in-range bin   | tdata: bin_number, real_part, imag_part, magnitude
//
// a bin request reads every sample once through the single sample memory port,
// then rounds, squares, sums and runs a 17-step bit-serial square root
// rst_n is asynchronous, active low, and clears the write pointer and control only
// a finished result waits in the output register while sample writes go on;
// a following bin request is computed meanwhile and its result holds the input
// off until that register is free
module real_dft_bin_magnitude_top #(
    parameter int POINTS = rdbm_pkg::POINTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample[15:0], bin_index[25:16], zero fill
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // bin_number[9:0], real_part[27:10],
                                   // imag_part[45:28], magnitude[62:46], zero fill
);

    localparam int LOG2N   = $clog2(POINTS);
    localparam int QUARTER = POINTS / 4;
    localparam int QW      = LOG2N - 2;
    localparam int ACC_W   = 32 + LOG2N;
    localparam int SH_FULL = 15 + LOG2N;
    localparam int SH_HALF = 14 + LOG2N;
    localparam int PART_W  = rdbm_pkg::PART_W;
    localparam int SQ_W    = rdbm_pkg::SQ_W;
    localparam int MAG_W   = rdbm_pkg::MAG_W;
    localparam int BIN_W   = rdbm_pkg::BIN_W;
    localparam int SAMPLE_W = rdbm_pkg::SAMPLE_W;

    typedef logic [33:0] rom_word_t;
    typedef rom_word_t rom_t [QUARTER];

    // shift-subtract quotient, only evaluated while building the table
    function automatic longint unsigned long_div(longint unsigned n, longint unsigned d);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            if (rem >= d)
            begin
                rem    = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave table, cos in the upper half, sin in the lower, both 0..32768
    function automatic rom_t build_rom();
        rom_t tab;
        longint unsigned x, x2, ts, tc;
        longint s, c, sq, cq;
        for (int i = 0; i < QUARTER; i++)
        begin
            x  = (64'd1686629713 * longint'(4 * i)) >> LOG2N;
            x2 = (x * x) >> 30;
            ts = x;
            tc = 64'd1 << 30;
            s  = 0;
            c  = 0;
            for (int k = 0; k < 12; k++)
            begin
                if (k % 2 == 1)
                begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end
                else
                begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
                ts = long_div((ts * x2) >> 30, 64'((2 * k + 2) * (2 * k + 3)));
                tc = long_div((tc * x2) >> 30, 64'((2 * k + 1) * (2 * k + 2)));
            end
            if (s < 0) s = 0;
            if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
            if (c < 0) c = 0;
            if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
            sq = (s + 16384) >>> 15;
            cq = (c + 16384) >>> 15;
            tab[i] = {cq[16:0], sq[16:0]};
        end
        return tab;
    endfunction

    localparam rom_t TW_ROM = build_rom();

    function automatic logic signed [15:0] sat16(logic signed [17:0] v);
        if (v > 18'sd32767)
        begin
            return 16'sd32767;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [PART_W-1:0] scale_round(
        logic signed [ACC_W-1:0] a, logic full);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] rnd;
        mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        if (full)
        begin
            rnd = (mag + (ACC_W'(1) << (SH_FULL - 1))) >> SH_FULL;
        end
        else
        begin
            rnd = (mag + (ACC_W'(1) << (SH_HALF - 1))) >> SH_HALF;
        end
        if (a[ACC_W-1])
        begin
            rnd = -rnd;
        end
        return rnd[PART_W-1:0];
    endfunction

    rdbm_pkg::state_t state_reg, state_next;

    logic [LOG2N-1:0]  wp_reg;
    logic [LOG2N:0]    j_reg;
    logic [LOG2N-1:0]  m_reg;
    logic [BIN_W-1:0]  bin_reg;
    logic              iss_reg;
    logic              prod_v_reg;
    logic [4:0]        it_reg;
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;

    logic signed [15:0]       cos_reg, sin_reg;
    logic signed [31:0]       p_re_reg, p_im_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [PART_W-1:0] re_reg, im_reg;
    logic [SQ_W-1:0]          sq_re_reg, sq_im_reg;
    logic [SQ_W-1:0]          v_reg, res_reg, bit_reg;

    logic                  s_accept;
    logic                  issue;
    logic [LOG2N-1:0]      ram_addr;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic                  ram_we;
    logic                  bin_ok;
    logic                  full_div;
    rom_word_t             rom_q;
    logic [1:0]            quad;
    logic signed [17:0]    c_ext, s_ext;
    logic signed [17:0]    cos_map, sin_map;
    logic [SQ_W-1:0]       trial;
    logic signed [2*PART_W-1:0] re_sq, im_sq;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == rdbm_pkg::ST_IDLE);
    assign bin_ok   = int'(s_tdata[25:16]) <= POINTS / 2;
    assign ram_we   = s_accept && (s_tuser == rdbm_pkg::KIND_SAMPLE);
    assign issue    = (state_reg == rdbm_pkg::ST_RUN) && (int'(j_reg) < POINTS);
    assign ram_addr = (state_reg == rdbm_pkg::ST_RUN) ? j_reg[LOG2N-1:0] : wp_reg;
    assign full_div = (bin_reg == '0) || (int'(bin_reg) == POINTS / 2);

    rdbm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata[15:0]),
        .rdata (ram_rdata)
    );

    // twiddle from the phase: quadrant from the top two bits
    assign rom_q = TW_ROM[m_reg[QW-1:0]];
    assign quad  = m_reg[LOG2N-1 -: 2];
    assign c_ext = $signed({1'b0, rom_q[33:17]});
    assign s_ext = $signed({1'b0, rom_q[16:0]});

    always_comb
    begin
        case (quad)
            2'd0:    begin cos_map = c_ext;  sin_map = s_ext;  end
            2'd1:    begin cos_map = -s_ext; sin_map = c_ext;  end
            2'd2:    begin cos_map = -c_ext; sin_map = -s_ext; end
            default: begin cos_map = s_ext;  sin_map = -c_ext; end
        endcase
    end

    assign trial = res_reg + bit_reg;
    assign re_sq = re_reg * re_reg;
    assign im_sq = im_reg * im_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rdbm_pkg::ST_IDLE:
            begin
                if (s_accept && (s_tuser == rdbm_pkg::KIND_BIN) && bin_ok)
                begin
                    state_next = rdbm_pkg::ST_RUN;
                end
            end
            rdbm_pkg::ST_RUN:
            begin
                if (!issue && !iss_reg && !prod_v_reg)
                begin
                    state_next = rdbm_pkg::ST_SCALE;
                end
            end
            rdbm_pkg::ST_SCALE:  state_next = rdbm_pkg::ST_SQUARE;
            rdbm_pkg::ST_SQUARE: state_next = rdbm_pkg::ST_SUM;
            rdbm_pkg::ST_SUM:    state_next = rdbm_pkg::ST_ROOT;
            rdbm_pkg::ST_ROOT:
            begin
                if (it_reg == 5'd16)
                begin
                    state_next = rdbm_pkg::ST_HOLD;
                end
            end
            rdbm_pkg::ST_HOLD:
            begin
                if (!m_tvalid_reg)
                begin
                    state_next = rdbm_pkg::ST_IDLE;
                end
            end
            default: state_next = rdbm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rdbm_pkg::ST_IDLE;
            wp_reg       <= '0;
            j_reg        <= '0;
            m_reg        <= '0;
            iss_reg      <= 1'b0;
            prod_v_reg   <= 1'b0;
            it_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_reg    <= issue;
            prod_v_reg <= iss_reg;
            if (ram_we)
            begin
                wp_reg <= wp_reg + LOG2N'(1);
            end
            if (state_reg == rdbm_pkg::ST_IDLE)
            begin
                j_reg <= '0;
                m_reg <= '0;
            end
            else if (issue)
            begin
                j_reg <= j_reg + (LOG2N + 1)'(1);
                m_reg <= m_reg + LOG2N'(bin_reg);
            end
            if (state_reg == rdbm_pkg::ST_SUM)
            begin
                it_reg <= '0;
            end
            else if (state_reg == rdbm_pkg::ST_ROOT)
            begin
                it_reg <= it_reg + 5'd1;
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            else if ((state_reg == rdbm_pkg::ST_HOLD) && !m_tvalid_reg)
            begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg  <= sat16(cos_map);
        sin_reg  <= sat16(sin_map);
        p_re_reg <= $signed(ram_rdata) * cos_reg;
        p_im_reg <= $signed(ram_rdata) * sin_reg;
        if (s_accept)
        begin
            bin_reg <= s_tdata[25:16];
        end
        if (state_reg == rdbm_pkg::ST_IDLE)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(p_re_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(p_im_reg);
        end
        if (state_reg == rdbm_pkg::ST_SCALE)
        begin
            re_reg <= scale_round(acc_re_reg, full_div);
            im_reg <= scale_round(acc_im_reg, full_div);
        end
        if (state_reg == rdbm_pkg::ST_SQUARE)
        begin
            sq_re_reg <= re_sq[SQ_W-1:0];
            sq_im_reg <= im_sq[SQ_W-1:0];
        end
        if (state_reg == rdbm_pkg::ST_SUM)
        begin
            v_reg   <= sq_re_reg + sq_im_reg;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << 32;
        end
        else if (state_reg == rdbm_pkg::ST_ROOT)
        begin
            // one result bit per cycle
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if ((state_reg == rdbm_pkg::ST_HOLD) && !m_tvalid_reg)
        begin
            m_tdata_reg <= {1'b0, res_reg[MAG_W-1:0], im_reg, re_reg, bin_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_req_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (s_tuser == rdbm_pkg::KIND_BIN) && bin_ok
        |=> state_reg == rdbm_pkg::ST_RUN)
        else $error("bin request did not start accumulation");

    a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rdbm_pkg::ST_SCALE |-> !iss_reg && !prod_v_reg)
        else $error("rounding began with products in flight");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == rdbm_pkg::ST_IDLE)
        else $error("sample write during a bin computation");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rdbm_pkg::ST_ROOT |-> it_reg <= 5'd16)
        else $error("square root ran past its last step");
`endif

endmodule

>>> hdl/rdbm_ram.sv
module rdbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
